// ----- rtl/plw_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the PLL register word builder.
// No dependencies; all rtl files but the checker refer to this package by scoped names.
package plw_pkg;

	localparam int FREQ_W = 23;
	localparam int REF_W  = 18;
	localparam int FRAC_W = 10;
	localparam int INT_W  = 14;
	localparam int CODE_W = 3;
	localparam int WORD_W = 32;

	// long division: integer part steps, then fraction digit steps
	localparam int N1_STEPS = FREQ_W;
	localparam int N2_STEPS = FRAC_W;

	// floor(2^37 / 10000), used to split off digits above 9999
	localparam logic [23:0] RECIP_10K  = 24'd13743895;
	localparam int          RECIP_SHFT = 37;

	localparam logic [2:0] REG_R5 = 3'd5;
	localparam logic [2:0] REG_R4 = 3'd4;
	localparam logic [2:0] REG_R3 = 3'd3;
	localparam logic [2:0] REG_R2 = 3'd2;
	localparam logic [2:0] REG_R1 = 3'd1;
	localparam logic [2:0] REG_R0 = 3'd0;

	localparam logic [31:0] R1_KEEP_MASK = 32'h1FFF_E007;

	typedef enum logic [2:0] {
		CFG_REF_CLOCK = 3'd0,
		CFG_REG5      = 3'd1,
		CFG_REG4_LOW  = 3'd2,
		CFG_REG3      = 3'd3,
		CFG_REG2      = 3'd4,
		CFG_REG1_TMPL = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [REF_W-1:0]  ref_khz;
		logic [31:0]       reg5;
		logic [19:0]       reg4_low;
		logic [31:0]       reg3;
		logic [31:0]       reg2;
		logic [31:0]       reg1_tmpl;
	} cfg_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [REF_W-1:0]  rem;
		logic [FREQ_W-1:0] num;
	} div1_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [FREQ_W-1:0] q1;
		logic [REF_W-1:0]  rem;
		logic [FRAC_W-1:0] num;
	} div2_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [FREQ_W-1:0] q1;
		logic [FRAC_W-1:0] f;
	} quo_t;

	typedef struct packed {
		logic [WORD_W-1:0] r4;
		logic [WORD_W-1:0] r1;
		logic [WORD_W-1:0] r0;
		logic [INT_W-1:0]  intv;
		logic [FRAC_W-1:0] frac;
		logic [FRAC_W-1:0] modv;
		logic [CODE_W-1:0] code;
	} res_t;

	// log2 of the output divider from the frequency band
	function automatic logic [CODE_W-1:0] pick_code(input logic [FREQ_W-1:0] freq);
		if (freq < 23'd69000) begin
			return 3'd6;
		end else if (freq < 23'd138000) begin
			return 3'd5;
		end else if (freq < 23'd275000) begin
			return 3'd4;
		end else if (freq < 23'd550000) begin
			return 3'd3;
		end else if (freq < 23'd1100000) begin
			return 3'd2;
		end else if (freq < 23'd2200000) begin
			return 3'd1;
		end
		return 3'd0;
	endfunction

	// one restoring step: returns {quotient bit, new remainder}
	function automatic logic [REF_W:0] div_step(input logic [REF_W-1:0] rem,
			input logic b, input logic [REF_W-1:0] dvsr);
		logic [REF_W:0] t;
		logic [REF_W:0] d;
		t = {rem, b};
		d = t - {1'b0, dvsr};
		if (t >= {1'b0, dvsr}) begin
			return {1'b1, d[REF_W-1:0]};
		end
		return {1'b0, t[REF_W-1:0]};
	endfunction

	// smallest modulus from the list for a three digit fraction: {mod, frac}
	function automatic logic [2*FRAC_W-1:0] mod_frac(input logic [FRAC_W-1:0] f);
		logic [6:0]  f8;
		logic [7:0]  f4;
		logic [12:0] p25;
		logic [15:0] p5a;
		logic [15:0] p5b;
		logic [2:0]  q25;
		logic [5:0]  q5a;
		logic [5:0]  q5b;
		logic [FRAC_W-1:0] mval;
		logic [FRAC_W-1:0] fval;
		f8  = f[9:3];
		f4  = f[9:2];
		p25 = 13'(f8) * 13'd41;
		p5a = 16'(f8) * 16'd205;
		p5b = 16'(f4) * 16'd205;
		q25 = p25[12:10];
		q5a = p5a[15:10];
		q5b = p5b[15:10];
		if (f == '0) begin
			mval = 10'd2;
			fval = '0;
		end else if (f[2:0] == 3'd0 && 7'(q25) * 7'd25 == f8) begin
			mval = 10'd5;
			fval = 10'(q25);
		end else if (f[2:0] == 3'd0 && 7'(q5a) * 7'd5 == f8) begin
			mval = 10'd25;
			fval = 10'(q5a);
		end else if (f[1:0] == 2'd0 && 8'(q5b) * 8'd5 == f4) begin
			mval = 10'd50;
			fval = 10'(q5b);
		end else if (f[2:0] == 3'd0) begin
			mval = 10'd125;
			fval = 10'(f8);
		end else if (f[1:0] == 2'd0) begin
			mval = 10'd250;
			fval = 10'(f4);
		end else if (f[0] == 1'b0) begin
			mval = 10'd500;
			fval = 10'(f[9:1]);
		end else begin
			mval = 10'd1000;
			fval = f;
		end
		return {mval, fval};
	endfunction

endpackage

// ----- rtl/plw_divider.sv -----
`timescale 1ns / 1ps
// Pipelined long divider: freq*div / ref as integer quotient plus three decimal digits.
// Uses plw_pkg types and the div_step function.
module plw_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [plw_pkg::FREQ_W-1:0]  in_freq,
	input  logic [plw_pkg::REF_W-1:0]   ref_khz,
	output logic                        out_valid,
	output plw_pkg::quo_t               out_quo
);

	logic [plw_pkg::N1_STEPS:0] v1_s;
	logic [plw_pkg::N2_STEPS:0] v2_s;
	plw_pkg::div1_t d1_s [plw_pkg::N1_STEPS+1];
	plw_pkg::div2_t d2_s [plw_pkg::N2_STEPS+1];

	logic [plw_pkg::CODE_W-1:0] code;
	logic [plw_pkg::FREQ_W-1:0] x;
	logic [27:0]                dprod;

	assign code  = plw_pkg::pick_code(in_freq);
	assign x     = in_freq << code;
	assign dprod = 28'(d1_s[plw_pkg::N1_STEPS].rem) * 28'd1000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= '0;
			v2_s <= '0;
		end else if (adv) begin
			v1_s <= {v1_s[plw_pkg::N1_STEPS-1:0], in_valid};
			v2_s <= {v2_s[plw_pkg::N2_STEPS-1:0], v1_s[plw_pkg::N1_STEPS]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s[0] <= '{code: code, rem: '0, num: x};
		end
	end

	for (genvar i = 0; i < plw_pkg::N1_STEPS; i++) begin : g_int
		logic [plw_pkg::REF_W:0] st;
		assign st = plw_pkg::div_step(d1_s[i].rem, d1_s[i].num[plw_pkg::FREQ_W-1], ref_khz);
		always_ff @(posedge clk) begin
			if (adv) begin
				d1_s[i+1] <= '{code: d1_s[i].code, rem: st[plw_pkg::REF_W-1:0],
					num: {d1_s[i].num[plw_pkg::FREQ_W-2:0], st[plw_pkg::REF_W]}};
			end
		end
	end

	// remainder * 1000; top bits already below ref, low ten shift in
	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s[0] <= '{code: d1_s[plw_pkg::N1_STEPS].code,
				q1: d1_s[plw_pkg::N1_STEPS].num, rem: dprod[27:10], num: dprod[9:0]};
		end
	end

	for (genvar j = 0; j < plw_pkg::N2_STEPS; j++) begin : g_frac
		logic [plw_pkg::REF_W:0] st;
		assign st = plw_pkg::div_step(d2_s[j].rem, d2_s[j].num[plw_pkg::FRAC_W-1], ref_khz);
		always_ff @(posedge clk) begin
			if (adv) begin
				d2_s[j+1] <= '{code: d2_s[j].code, q1: d2_s[j].q1,
					rem: st[plw_pkg::REF_W-1:0],
					num: {d2_s[j].num[plw_pkg::FRAC_W-2:0], st[plw_pkg::REF_W]}};
			end
		end
	end

	assign out_valid = v2_s[plw_pkg::N2_STEPS];
	assign out_quo   = '{code: d2_s[plw_pkg::N2_STEPS].code, q1: d2_s[plw_pkg::N2_STEPS].q1,
		f: d2_s[plw_pkg::N2_STEPS].num};

endmodule

// ----- rtl/plw_post.sv -----
`timescale 1ns / 1ps
// Three stage back end: INT mod 10000, FRAC/MOD reduction, R4/R1/R0 assembly.
// Uses plw_pkg types, constants and mod_frac.
module plw_post (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  plw_pkg::quo_t in_quo,
	input  plw_pkg::cfg_t cfg,
	output logic          out_valid,
	output plw_pkg::res_t out_res
);

	logic [2:0]                  v_s;
	logic [46:0]                 prod_s1;
	logic [plw_pkg::FREQ_W-1:0]  q1_s1;
	logic [plw_pkg::CODE_W-1:0]  code_s1, code_s2;
	logic [plw_pkg::FRAC_W-1:0]  mod_s1, mod_s2, frac_s1, frac_s2;
	logic [14:0]                 r_s2;
	plw_pkg::res_t               res_s3;

	logic [2*plw_pkg::FRAC_W-1:0] mf;
	logic [9:0]                   est;
	logic [plw_pkg::FREQ_W-1:0]   sub;
	logic [14:0]                  rc;
	logic [plw_pkg::INT_W-1:0]    intv;

	assign mf   = plw_pkg::mod_frac(in_quo.f);
	assign est  = prod_s1[46:plw_pkg::RECIP_SHFT];
	assign sub  = q1_s1 - 23'(est) * 23'd10000;
	assign rc   = (r_s2 >= 15'd10000) ? (r_s2 - 15'd10000) : r_s2;
	assign intv = rc[plw_pkg::INT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= 47'(in_quo.q1) * 47'(plw_pkg::RECIP_10K);
			q1_s1   <= in_quo.q1;
			code_s1 <= in_quo.code;
			mod_s1  <= mf[2*plw_pkg::FRAC_W-1:plw_pkg::FRAC_W];
			frac_s1 <= mf[plw_pkg::FRAC_W-1:0];

			r_s2    <= sub[14:0];
			code_s2 <= code_s1;
			mod_s2  <= mod_s1;
			frac_s2 <= frac_s1;

			res_s3.r4   <= {8'h00, 1'b1, code_s2, cfg.reg4_low};
			res_s3.r1   <= (cfg.reg1_tmpl & plw_pkg::R1_KEEP_MASK) | {19'd0, mod_s2, 3'd0};
			res_s3.r0   <= {3'b000, intv, 2'b00, frac_s2, 3'b000};
			res_s3.intv <= intv;
			res_s3.frac <= frac_s2;
			res_s3.modv <= mod_s2;
			res_s3.code <= code_s2;
		end
	end

	assign out_valid = v_s[2];
	assign out_res   = res_s3;

endmodule

// ----- rtl/plw_serializer.sv -----
`timescale 1ns / 1ps
// Output register that sends one request's six words, R5 first, R0 with tlast.
// Uses plw_pkg types and register number constants.
module plw_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  plw_pkg::res_t in_res,
	input  plw_pkg::cfg_t cfg,
	output logic          adv,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [71:0]   m_axis_tdata,
	output logic [2:0]    m_axis_tuser,
	output logic          m_axis_tlast
);

	logic          busy_q;
	logic [2:0]    cnt_q;
	plw_pkg::res_t res_q;
	logic          beat, fin, take;
	logic [31:0]   word;

	assign beat = busy_q && m_axis_tready;
	assign fin  = beat && (cnt_q == plw_pkg::REG_R0);
	assign take = !busy_q || fin;
	assign adv  = take || !in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= plw_pkg::REG_R5;
		end else if (take) begin
			busy_q <= in_valid;
			cnt_q  <= plw_pkg::REG_R5;
		end else if (beat) begin
			cnt_q  <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			res_q <= in_res;
		end
	end

	always_comb begin
		unique case (cnt_q)
			plw_pkg::REG_R5: word = cfg.reg5;
			plw_pkg::REG_R4: word = res_q.r4;
			plw_pkg::REG_R3: word = cfg.reg3;
			plw_pkg::REG_R2: word = cfg.reg2;
			plw_pkg::REG_R1: word = res_q.r1;
			default:         word = res_q.r0;
		endcase
	end

	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = {3'b000, res_q.code, res_q.modv, res_q.frac, res_q.intv, word};
	assign m_axis_tuser  = cnt_q;
	assign m_axis_tlast  = (cnt_q == plw_pkg::REG_R0);

endmodule

// ----- rtl/pll_register_word_builder.sv -----
`timescale 1ns / 1ps
// Top level: configuration registers, divider pipeline, back end and output serializer.
// Depends on plw_pkg, plw_divider, plw_post and plw_serializer.
//
// Each accepted request beat (an output frequency in kHz) produces six output beats
// carrying the synthesizer words R5, R4, R3, R2, R1, R0 in that order, with tlast on R0
// and the register number on tuser. The divider pipeline is 35 stages deep and the back
// end 3 more. The pipeline takes a new request every cycle unless a finished result waits
// on a busy serializer; sustained throughput is set by the output serializer, which sends
// the six words of each request one word per beat.
// Configuration registers are written through the cfg channel, which is always ready,
// and must only change while no request is in flight. A zero reference reads as 1 kHz.
module pll_register_word_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [22:0] freq_khz, [23] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] reg_word, [45:32] int_value, [55:46] frac_num, [65:56] modulus,
	// [68:66] divider_code, [71:69] zero
	output logic [71:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,   // [2:0] reg_number
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	plw_pkg::cfg_t             cfg_q;
	logic [plw_pkg::REF_W-1:0] ref_eff;
	logic                      adv;
	logic                      div_valid, post_valid;
	plw_pkg::quo_t             div_quo;
	plw_pkg::res_t             post_res;

	assign cfg_ready = 1'b1;
	assign ref_eff   = (cfg_q.ref_khz == '0) ? 18'd1 : cfg_q.ref_khz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_khz   <= 18'd25000;
			cfg_q.reg5      <= 32'h0058_0005;
			cfg_q.reg4_low  <= 20'hC803C;
			cfg_q.reg3      <= 32'h0000_04B3;
			cfg_q.reg2      <= 32'h0000_4E42;
			cfg_q.reg1_tmpl <= 32'h0800_8011;
		end else if (cfg_valid && cfg_ready) begin
			unique case (plw_pkg::cfg_idx_t'(cfg_index))
				plw_pkg::CFG_REF_CLOCK: cfg_q.ref_khz   <= cfg_data[plw_pkg::REF_W-1:0];
				plw_pkg::CFG_REG5:      cfg_q.reg5      <= cfg_data;
				plw_pkg::CFG_REG4_LOW:  cfg_q.reg4_low  <= cfg_data[19:0];
				plw_pkg::CFG_REG3:      cfg_q.reg3      <= cfg_data;
				plw_pkg::CFG_REG2:      cfg_q.reg2      <= cfg_data;
				plw_pkg::CFG_REG1_TMPL: cfg_q.reg1_tmpl <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = adv;

	plw_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_axis_tvalid),
		.in_freq   (s_axis_tdata[plw_pkg::FREQ_W-1:0]),
		.ref_khz   (ref_eff),
		.out_valid (div_valid),
		.out_quo   (div_quo)
	);

	plw_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (div_valid),
		.in_quo    (div_quo),
		.cfg       (cfg_q),
		.out_valid (post_valid),
		.out_res   (post_res)
	);

	plw_serializer u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (post_valid),
		.in_res        (post_res),
		.cfg           (cfg_q),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- rtl/plw_checker.sv -----
`timescale 1ns / 1ps
// Port level checks on the output word stream, bound to pll_register_word_builder.
// No package dependency.
module plw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	a_regno_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= 3'd5))
		else $error("register number out of range");

	a_last_on_r0: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd0)))
		else $error("tlast not on R0 word");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser != 3'd0) |=>
		(m_axis_tvalid && m_axis_tuser == 3'($past(m_axis_tuser) - 3'd1)
			&& $stable(m_axis_tdata[71:32])))
		else $error("word run broken or fields changed inside a run");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled beat changed");

endmodule

bind pll_register_word_builder plw_checker u_plw_checker (.*);
